// ===== design/sws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sws_pkg;

    // Ring and frame geometry.
    localparam int RING_SLOTS  = 8;
    localparam int FRAME_BYTES = 28;
    localparam int SENSORS     = 4;
    localparam int VALUES      = 3 * SENSORS;

    localparam int SLOT_W  = $clog2(RING_SLOTS);
    localparam int CNT_W   = $clog2(FRAME_BYTES);
    localparam int ADDR_W  = $clog2(RING_SLOTS * FRAME_BYTES);
    localparam int VIDX_W  = $clog2(VALUES);
    localparam int FREE_W  = $clog2(RING_SLOTS + 1);
    localparam int QUEUE_CAP = (RING_SLOTS > 15) ? RING_SLOTS : 15;
    localparam int QUEUE_W = $clog2(QUEUE_CAP + 1);

    // Stream widths.
    localparam int IN_DATA_W  = 72;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_SLOT_W = 3;

    // Feedback codes.
    localparam logic [7:0] CODE_ACK    = 8'h41;
    localparam logic [7:0] CODE_RESEND = 8'h4E;

    // Byte positions inside a frame.
    localparam logic [CNT_W-1:0] BYTE_ID_LO  = CNT_W'(0);
    localparam logic [CNT_W-1:0] BYTE_ID_HI  = CNT_W'(1);
    localparam logic [CNT_W-1:0] BYTE_VAL_LO = CNT_W'(2);
    localparam logic [CNT_W-1:0] BYTE_VAL_HI = CNT_W'(2 * VALUES + 1);
    localparam logic [CNT_W-1:0] BYTE_SUM_LO = CNT_W'(FRAME_BYTES - 2);
    localparam logic [CNT_W-1:0] BYTE_LAST   = CNT_W'(FRAME_BYTES - 1);

    typedef enum logic [1:0] {
        OP_REPORT   = 2'd0,
        OP_SEND     = 2'd1,
        OP_FEEDBACK = 2'd2
    } sws_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUILD,
        ST_STATUS,
        ST_SEND
    } sws_state_t;

    // Control from the sequencer to the sensor bank.
    typedef struct packed {
        logic              wr;
        logic [1:0]        sensor;
        logic              start;
        logic              step;
        logic [CNT_W-1:0]  cnt;
        logic [SLOT_W-1:0] id;
    } sws_bank_ctrl_t;

endpackage

`default_nettype wire

// ===== design/sliding_window_frame_sender_unit.sv =====
// A report that completes a round writes its frame into the frame RAM byte by byte and then
// shows its status transfer (on overflow the status goes out with no frame write); a send
// tick shows its frame bytes one per cycle while the output does not stall.
// Input is taken only while idle, so a new item waits until the frame write, status transfer
// or frame send of the last one is through; output stalls hold the status and send states.
// Reset clears all control state; per-slot valid bits make unwritten slots read as zero.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_frame_sender_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // sensor_index, value_x, value_y, value_z, ack_code, ack_frame, zero pad
    input  wire logic [sws_pkg::IN_DATA_W-1:0]  s_tdata,
    // operation
    input  wire logic [sws_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // frame_byte, overflow, slot, zero pad
    output logic [sws_pkg::OUT_DATA_W-1:0]      m_tdata,
    // kind
    output logic [0:0]                          m_tuser,
    // last_byte
    output logic                                m_tlast
);
    import sws_pkg::*;

    // Input fields.
    logic [1:0]  in_sensor;
    logic [15:0] in_x;
    logic [15:0] in_y;
    logic [15:0] in_z;
    logic [7:0]  in_code;
    logic [7:0]  in_frame;

    assign in_sensor = s_tdata[1:0];
    assign in_x      = s_tdata[17:2];
    assign in_y      = s_tdata[33:18];
    assign in_z      = s_tdata[49:34];
    assign in_code   = s_tdata[57:50];
    assign in_frame  = s_tdata[65:58];

    sws_state_t state_reg;
    sws_state_t state_next;

    logic [CNT_W-1:0]      cnt_reg;
    logic [SLOT_W-1:0]     cur_reg;
    logic                  st_ovf_reg;
    logic [SLOT_W-1:0]     fill_reg;
    logic [SLOT_W-1:0]     send_reg;
    logic [FREE_W-1:0]     free_reg;
    logic [QUEUE_W-1:0]    queued_reg;
    logic [RING_SLOTS-1:0] row_valid_reg;

    logic                  m_valid_reg;
    logic                  m_kind_reg;
    logic                  m_last_reg;
    logic                  m_ovf_reg;
    logic [SLOT_W-1:0]     m_slot_reg;
    logic                  m_row_ok_reg;

    logic                  accept;
    logic                  out_free;
    logic                  round_done;
    logic [7:0]            build_byte;
    logic [7:0]            rd_data;
    logic [ADDR_W-1:0]     addr;
    logic                  ram_wr;
    logic                  ram_rd;
    logic                  load_status;
    logic                  build_end;
    logic                  send_end;
    sws_bank_ctrl_t        bank_ctrl;

    logic [SLOT_W-1:0]     ack_id;
    logic [SLOT_W:0]       ack_diff;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        slot_inc = (s == SLOT_W'(RING_SLOTS - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign build_end = (cnt_reg == BYTE_LAST);
    assign send_end  = (cnt_reg == BYTE_LAST);
    assign addr      = ADDR_W'(cur_reg * FRAME_BYTES) + ADDR_W'(cnt_reg);

    // Free count after an acknowledge: distance from fill slot to id, plus one.
    always_comb
    begin
        ack_id = SLOT_W'(in_frame % RING_SLOTS);
        if (ack_id >= fill_reg)
        begin
            ack_diff = {1'b0, ack_id} - {1'b0, fill_reg};
        end
        else
        begin
            ack_diff = {1'b0, ack_id} + (SLOT_W + 1)'(RING_SLOTS) - {1'b0, fill_reg};
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_tuser == OP_REPORT) && round_done)
                begin
                    state_next = (free_reg == '0) ? ST_STATUS : ST_BUILD;
                end
                else if (accept && (s_tuser == OP_SEND) && (queued_reg != '0))
                begin
                    state_next = ST_SEND;
                end
            end
            ST_BUILD:
            begin
                if (build_end)
                begin
                    state_next = ST_STATUS;
                end
            end
            ST_STATUS:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEND:
            begin
                if (out_free && send_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb
    begin
        s_tready    = 1'b0;
        ram_wr      = 1'b0;
        ram_rd      = 1'b0;
        load_status = 1'b0;
        bank_ctrl.wr     = 1'b0;
        bank_ctrl.sensor = in_sensor;
        bank_ctrl.start  = 1'b0;
        bank_ctrl.step   = 1'b0;
        bank_ctrl.cnt    = cnt_reg;
        bank_ctrl.id     = cur_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready        = 1'b1;
                bank_ctrl.wr    = s_tvalid && (s_tuser == OP_REPORT);
                bank_ctrl.start = bank_ctrl.wr && round_done;
                bank_ctrl.id    = fill_reg;
            end
            ST_BUILD:
            begin
                ram_wr         = 1'b1;
                bank_ctrl.step = 1'b1;
            end
            ST_STATUS:
            begin
                load_status = out_free;
            end
            ST_SEND:
            begin
                ram_rd = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // Ring bookkeeping and the sequencer counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            cur_reg       <= '0;
            st_ovf_reg    <= 1'b0;
            fill_reg      <= '0;
            send_reg      <= '0;
            free_reg      <= FREE_W'(RING_SLOTS);
            queued_reg    <= '0;
            row_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg <= '0;
                case (s_tuser)
                    OP_REPORT:
                    begin
                        if (round_done)
                        begin
                            cur_reg <= fill_reg;
                            if (free_reg == '0)
                            begin
                                st_ovf_reg <= 1'b1;
                            end
                            else
                            begin
                                st_ovf_reg              <= 1'b0;
                                fill_reg                <= slot_inc(fill_reg);
                                free_reg                <= free_reg - FREE_W'(1);
                                row_valid_reg[fill_reg] <= 1'b1;
                                if (queued_reg != QUEUE_W'(QUEUE_CAP))
                                begin
                                    queued_reg <= queued_reg + QUEUE_W'(1);
                                end
                            end
                        end
                    end
                    OP_SEND:
                    begin
                        if (queued_reg != '0)
                        begin
                            cur_reg    <= send_reg;
                            send_reg   <= slot_inc(send_reg);
                            queued_reg <= queued_reg - QUEUE_W'(1);
                        end
                    end
                    OP_FEEDBACK:
                    begin
                        if (in_code == CODE_ACK)
                        begin
                            free_reg <= FREE_W'(ack_diff) + FREE_W'(1);
                        end
                        else if (in_code == CODE_RESEND)
                        begin
                            send_reg <= ack_id;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (ram_wr || ram_rd)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // Output register: valid and the fields that travel with each transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (load_status || ram_rd)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_status)
        begin
            m_kind_reg <= 1'b1;
            m_last_reg <= 1'b0;
            m_ovf_reg  <= st_ovf_reg;
            m_slot_reg <= cur_reg;
        end
        else if (ram_rd)
        begin
            m_kind_reg   <= 1'b0;
            m_last_reg   <= send_end;
            m_ovf_reg    <= 1'b0;
            m_slot_reg   <= cur_reg;
            m_row_ok_reg <= row_valid_reg[cur_reg];
        end
    end

    sws_sensor_bank u_bank (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (bank_ctrl),
        .value_x    (in_x),
        .value_y    (in_y),
        .value_z    (in_z),
        .round_done (round_done),
        .build_byte (build_byte)
    );

    sws_frame_ram u_ram (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (addr),
        .wr_data (build_byte),
        .rd_en   (ram_rd),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    // Frame bytes of a never-written slot read as zero.
    assign m_tvalid   = m_valid_reg;
    assign m_tuser    = m_kind_reg;
    assign m_tlast    = m_last_reg;
    assign m_tdata    = {4'b0000, OUT_SLOT_W'(m_slot_reg), m_ovf_reg,
                         (!m_kind_reg && m_row_ok_reg) ? rd_data : 8'h00};

endmodule

`default_nettype wire

// ===== design/sws_frame_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sws_frame_ram (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [sws_pkg::ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]                wr_data,
    input  wire logic                      rd_en,
    input  wire logic [sws_pkg::ADDR_W-1:0] rd_addr,
    output logic      [7:0]                rd_data
);
    import sws_pkg::*;

    logic [7:0] mem [RING_SLOTS * FRAME_BYTES];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/sws_sensor_bank.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sws_sensor_bank (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire sws_pkg::sws_bank_ctrl_t ctrl,
    input  wire logic [15:0]             value_x,
    input  wire logic [15:0]             value_y,
    input  wire logic [15:0]             value_z,
    output logic                         round_done,
    output logic [7:0]                   build_byte
);
    import sws_pkg::*;

    logic [15:0]        values_reg [VALUES];
    logic [SENSORS-1:0] mask_reg;
    logic [15:0]        sum_reg;
    logic [SENSORS-1:0] mask_set;
    logic [CNT_W-1:0]   vpos;
    logic [VIDX_W-1:0]  vidx;
    logic [15:0]        vsel;
    logic               in_values;

    // The round completes when this report fills the last mask bit.
    always_comb
    begin
        mask_set   = mask_reg | (SENSORS'(1) << ctrl.sensor);
        round_done = (mask_set == {SENSORS{1'b1}});
    end

    // Value word addressed by the current frame byte.
    always_comb
    begin
        in_values = (ctrl.cnt >= BYTE_VAL_LO) && (ctrl.cnt <= BYTE_VAL_HI);
        vpos      = ctrl.cnt - BYTE_VAL_LO;
        vidx      = in_values ? VIDX_W'(vpos >> 1) : VIDX_W'(VALUES - 1);
        vsel      = values_reg[vidx];
    end

    // Frame byte for the current build position.
    always_comb
    begin
        if (ctrl.cnt == BYTE_ID_LO)
        begin
            build_byte = 8'(ctrl.id);
        end
        else if (ctrl.cnt == BYTE_ID_HI)
        begin
            build_byte = 8'h00;
        end
        else if (in_values)
        begin
            build_byte = ctrl.cnt[0] ? vsel[15:8] : vsel[7:0];
        end
        else if (ctrl.cnt == BYTE_SUM_LO)
        begin
            build_byte = sum_reg[7:0];
        end
        else
        begin
            build_byte = sum_reg[15:8];
        end
    end

    // Readings and the report mask.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            for (int i = 0; i < VALUES; i++)
            begin
                values_reg[i] <= '0;
            end
        end
        else if (ctrl.wr)
        begin
            values_reg[3 * ctrl.sensor + 0] <= value_x;
            values_reg[3 * ctrl.sensor + 1] <= value_y;
            values_reg[3 * ctrl.sensor + 2] <= value_z;
            mask_reg <= round_done ? '0 : mask_set;
        end
    end

    // Checksum folds in each word as its high byte goes out.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            sum_reg <= 16'(ctrl.id);
        end
        else if (ctrl.step && in_values && ctrl.cnt[0])
        begin
            sum_reg <= sum_reg ^ vsel;
        end
    end

endmodule

`default_nettype wire
